[src/xcfp_pkg.sv]
// Shared types, constants and codes for the XOR-checked frame parser.
package xcfp_pkg;

  // Sizes of the payload store and the frame counters
  localparam int PayloadBytes = 16;
  localparam int CountBits    = 16;

  // Fixed field widths
  localparam int ByteW     = 8;
  localparam int LenW      = 5;
  localparam int StatusW   = 2;
  localparam int CountOutW = 16;
  localparam int WordW     = 64;
  localparam int SlotBytes = 16;
  localparam int IdxW      = (PayloadBytes > 1) ? $clog2(PayloadBytes) : 1;
  localparam int CfgIdxW   = 1;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_BYTE = 1'b0,
    CFG_MAX_LENGTH = 1'b1
  } cfg_reg_e;

  // Frame status codes
  typedef enum logic [StatusW-1:0] {
    ST_GOOD       = 2'd0,
    ST_BAD_CHECK  = 2'd1,
    ST_BAD_LENGTH = 2'd2
  } status_e;

  // Parser phases
  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_LEN     = 3'd1,
    PH_CMD     = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CHECK   = 3'd4
  } phase_e;

  // Configuration as seen by the parser
  typedef struct packed {
    logic [ByteW-1:0] start_byte;
    logic [LenW-1:0]  max_length;
  } cfg_t;

  // One finished-frame result
  typedef struct packed {
    status_e              status;
    logic [ByteW-1:0]     command;
    logic [LenW-1:0]      payload_length;
    logic [WordW-1:0]     payload_low;
    logic [WordW-1:0]     payload_high;
    logic [CountOutW-1:0] good_count;
    logic [CountOutW-1:0] bad_count;
  } result_t;

endpackage

[src/xcfp_in_reg.sv]
// Input word register of the frame parser.
module xcfp_in_reg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [xcfp_pkg::ByteW-1:0] rx_byte_i,
  input  logic                      adv_i,
  output logic                      byte_valid_o,
  output logic [xcfp_pkg::ByteW-1:0] byte_o
);
  import xcfp_pkg::*;

  logic             vld_q, vld_d;
  logic [ByteW-1:0] byte_q;
  logic             accept;

  // Take a new word when empty or when the held word moves on
  assign in_ready_o = !vld_q || adv_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (adv_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Hold the payload until consumed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= rx_byte_i;
    end
  end

  assign byte_valid_o = vld_q;
  assign byte_o       = byte_q;

endmodule

[src/xcfp_deframer.sv]
// Frame state machine, payload store, check and counters of the frame parser.
module xcfp_deframer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic [xcfp_pkg::ByteW-1:0] byte_i,
  input  xcfp_pkg::cfg_t             cfg_i,
  output logic                       res_valid_o,
  output xcfp_pkg::result_t          res_o
);
  import xcfp_pkg::*;

  localparam logic [LenW-1:0] PayloadLen = LenW'(PayloadBytes);

  phase_e                phase_q, phase_d;
  logic [LenW-1:0]       len_q, len_d;
  logic [ByteW-1:0]      cmd_q, cmd_d;
  logic [LenW-1:0]       idx_q, idx_d;
  logic [ByteW-1:0]      chk_q, chk_d;
  logic [CountBits-1:0]  good_q, good_d;
  logic [CountBits-1:0]  bad_q, bad_d;
  logic [ByteW-1:0]      store_q [PayloadBytes];

  logic [LenW-1:0]       limit;
  logic                  too_long;
  logic [LenW-1:0]       idx_inc;
  logic                  store_we;
  logic                  with_body;
  status_e               status;
  logic [2*WordW-1:0]    body;
  logic [CountOutW-1:0]  good_out;
  logic [CountOutW-1:0]  bad_out;

  // Clamp the length limit to the store size
  assign limit    = (cfg_i.max_length > PayloadLen) ? PayloadLen : cfg_i.max_length;
  assign too_long = byte_i > ByteW'(limit);
  assign idx_inc  = idx_q + LenW'(1);

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (step_i) begin
      unique case (phase_q)
        PH_HUNT:    if (byte_i == cfg_i.start_byte) begin
                      phase_d = PH_LEN;
                    end
        PH_LEN:     phase_d = too_long ? PH_HUNT : PH_CMD;
        PH_CMD:     phase_d = (len_q == '0) ? PH_CHECK : PH_PAYLOAD;
        PH_PAYLOAD: if (idx_inc >= len_q) begin
                      phase_d = PH_CHECK;
                    end
        PH_CHECK:   phase_d = PH_HUNT;
        default:    phase_d = PH_HUNT;
      endcase
    end
  end

  // Datapath updates and result strobe
  always_comb begin
    len_d       = len_q;
    cmd_d       = cmd_q;
    idx_d       = idx_q;
    chk_d       = chk_q;
    good_d      = good_q;
    bad_d       = bad_q;
    store_we    = 1'b0;
    res_valid_o = 1'b0;
    with_body   = 1'b0;
    status      = ST_GOOD;
    if (step_i) begin
      unique case (phase_q)
        PH_HUNT: begin
          if (byte_i == cfg_i.start_byte) begin
            chk_d = '0;
          end
        end
        PH_LEN: begin
          if (too_long) begin
            bad_d       = bad_q + CountBits'(1);
            res_valid_o = 1'b1;
            status      = ST_BAD_LENGTH;
          end else begin
            len_d = byte_i[LenW-1:0];
            chk_d = byte_i;
          end
        end
        PH_CMD: begin
          cmd_d = byte_i;
          chk_d = chk_q ^ byte_i;
          idx_d = '0;
        end
        PH_PAYLOAD: begin
          store_we = idx_q < PayloadLen;
          idx_d    = idx_inc;
          chk_d    = chk_q ^ byte_i;
        end
        PH_CHECK: begin
          res_valid_o = 1'b1;
          with_body   = 1'b1;
          if (byte_i == chk_q) begin
            good_d = good_q + CountBits'(1);
            status = ST_GOOD;
          end else begin
            bad_d  = bad_q + CountBits'(1);
            status = ST_BAD_CHECK;
          end
        end
        default: begin
          chk_d = chk_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      len_q   <= '0;
      cmd_q   <= '0;
      idx_q   <= '0;
      chk_q   <= '0;
      good_q  <= '0;
      bad_q   <= '0;
    end else begin
      phase_q <= phase_d;
      len_q   <= len_d;
      cmd_q   <= cmd_d;
      idx_q   <= idx_d;
      chk_q   <= chk_d;
      good_q  <= good_d;
      bad_q   <= bad_d;
    end
  end

  // Payload store, written one byte per payload word
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[idx_q[IdxW-1:0]] <= byte_i;
    end
  end

  // Pack payload slots, zero beyond the frame length
  for (genvar i = 0; i < SlotBytes; i++) begin : g_slot
    if (i < PayloadBytes) begin : g_stored
      assign body[ByteW*i +: ByteW] = (LenW'(i) < len_q) ? store_q[i] : '0;
    end else begin : g_empty
      assign body[ByteW*i +: ByteW] = '0;
    end
  end

  // Fit the counters to the output width
  if (CountBits >= CountOutW) begin : g_cnt_trunc
    assign good_out = good_d[CountOutW-1:0];
    assign bad_out  = bad_d[CountOutW-1:0];
  end else begin : g_cnt_ext
    assign good_out = {{(CountOutW-CountBits){1'b0}}, good_d};
    assign bad_out  = {{(CountOutW-CountBits){1'b0}}, bad_d};
  end

  // Assemble the result
  always_comb begin
    res_o.status         = status;
    res_o.command        = with_body ? cmd_q : '0;
    res_o.payload_length = with_body ? len_q : '0;
    res_o.payload_low    = with_body ? body[WordW-1:0] : '0;
    res_o.payload_high   = with_body ? body[2*WordW-1:WordW] : '0;
    res_o.good_count     = good_out;
    res_o.bad_count      = bad_out;
  end

endmodule

[src/xcfp_out_reg.sv]
// Result register of the frame parser.
module xcfp_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  xcfp_pkg::result_t res_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output xcfp_pkg::result_t res_o
);
  import xcfp_pkg::*;

  logic    vld_q, vld_d;
  result_t res_q;

  // Slot can take a result when empty or being drained
  assign free_o = !vld_q || out_ready_i;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = 1'b1;
    end else if (out_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = vld_q;
  assign res_o       = res_q;

endmodule

[src/xor_checked_frame_parser.sv]
// Top level of the XOR-checked frame parser.
//
// Input channel: one received byte per word on rx_byte_i, valid/ready.
// Frames are start byte, length, command, payload, XOR check byte; bytes
// outside a frame are dropped. Output channel: one word per finished frame
// (good, bad check or bad length) with command, length, payload packed into
// two 64-bit words, and wrapping good/bad frame counts.
// Configuration channel: cfg_index_i selects start byte (0) or maximum
// length (1), written from cfg_data_i whenever cfg_valid_i is high.
// Throughput: one input word per cycle while the result slot is free. A
// frame's check byte (or oversized length byte) first sits in the input
// register; its result is loaded into the result register once that slot
// is free, and out_valid_o then rises.
// Reset clears the parser to hunting, the counters to zero and the
// configuration to start byte 2 and maximum length 15. When the receiver
// stalls, the result is held and the parser stops advancing; the input
// register takes at most one more word, then in_ready_o drops until the
// held result is taken.
module xor_checked_frame_parser (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [xcfp_pkg::ByteW-1:0]         rx_byte_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [xcfp_pkg::StatusW-1:0]       status_o,
  output logic [xcfp_pkg::ByteW-1:0]         command_o,
  output logic [xcfp_pkg::LenW-1:0]          payload_length_o,
  output logic [xcfp_pkg::WordW-1:0]         payload_low_o,
  output logic [xcfp_pkg::WordW-1:0]         payload_high_o,
  output logic [xcfp_pkg::CountOutW-1:0]     good_count_o,
  output logic [xcfp_pkg::CountOutW-1:0]     bad_count_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [xcfp_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [xcfp_pkg::ByteW-1:0]         cfg_data_i
);
  import xcfp_pkg::*;

  cfg_t             cfg_q;
  logic             byte_valid;
  logic [ByteW-1:0] byte_held;
  logic             free;
  logic             adv;
  logic             res_valid;
  result_t          res_new;
  result_t          res_out;

  // Configuration registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte <= ByteW'(2);
      cfg_q.max_length <= LenW'(15);
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_START_BYTE: cfg_q.start_byte <= cfg_data_i;
        CFG_MAX_LENGTH: cfg_q.max_length <= cfg_data_i[LenW-1:0];
        default:        cfg_q            <= cfg_q;
      endcase
    end
  end

  // Advance the held word when the result slot is free
  assign adv = byte_valid && free;

  xcfp_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .rx_byte_i   (rx_byte_i),
    .adv_i       (adv),
    .byte_valid_o(byte_valid),
    .byte_o      (byte_held)
  );

  xcfp_deframer u_deframer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (adv),
    .byte_i     (byte_held),
    .cfg_i      (cfg_q),
    .res_valid_o(res_valid),
    .res_o      (res_new)
  );

  xcfp_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (res_valid),
    .res_i      (res_new),
    .free_o     (free),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .res_o      (res_out)
  );

  assign status_o         = res_out.status;
  assign command_o        = res_out.command;
  assign payload_length_o = res_out.payload_length;
  assign payload_low_o    = res_out.payload_low;
  assign payload_high_o   = res_out.payload_high;
  assign good_count_o     = res_out.good_count;
  assign bad_count_o      = res_out.bad_count;

endmodule

[src/xcfp_checker.sv]
// Port-level checks for the frame parser, bound to the top level.
module xcfp_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [xcfp_pkg::StatusW-1:0]   status_o,
  input logic [xcfp_pkg::ByteW-1:0]     command_o,
  input logic [xcfp_pkg::LenW-1:0]      payload_length_o,
  input logic [xcfp_pkg::WordW-1:0]     payload_low_o,
  input logic [xcfp_pkg::WordW-1:0]     payload_high_o,
  input logic [xcfp_pkg::CountOutW-1:0] good_count_o,
  input logic [xcfp_pkg::CountOutW-1:0] bad_count_o
);
  import xcfp_pkg::*;

  // Result held while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
      $stable(good_count_o) && $stable(bad_count_o) && $stable(payload_low_o))
    else $error("result changed while stalled");

  // No result word in the cycle after reset is seen
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid during reset");

  // Length error carries an empty body
  a_len_err_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_BAD_LENGTH |->
      command_o == '0 && payload_length_o == '0 &&
      payload_low_o == '0 && payload_high_o == '0)
    else $error("length error with nonzero body");

  // Status code and length stay in range
  a_ranges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_GOOD || status_o == ST_BAD_CHECK ||
      status_o == ST_BAD_LENGTH) && payload_length_o <= LenW'(PayloadBytes))
    else $error("status or length out of range");

endmodule

bind xor_checked_frame_parser xcfp_checker u_xcfp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .status_o        (status_o),
  .command_o       (command_o),
  .payload_length_o(payload_length_o),
  .payload_low_o   (payload_low_o),
  .payload_high_o  (payload_high_o),
  .good_count_o    (good_count_o),
  .bad_count_o     (bad_count_o)
);

[tb/xcfp_tb_pkg.sv]
// Frame ledger for the XOR-checked frame parser testbench: predicts and checks frame results.
package xcfp_tb_pkg;
  import xcfp_pkg::*;

  class frame_ledger;
    // Frames predicted but not yet seen on the output
    result_t pending_frames[$];

    // Run statistics and failures
    int unsigned mismatches;
    int unsigned words_seen;
    int unsigned frames_checked;
    int unsigned n_good;
    int unsigned n_bad_check;
    int unsigned n_bad_length;

    // Register copies
    logic [ByteW-1:0] start_byte;
    logic [LenW-1:0]  max_length;

    // Parser state copy
    phase_e               parse_phase;
    logic [LenW-1:0]      frame_len;
    logic [ByteW-1:0]     frame_cmd;
    logic [LenW-1:0]      byte_idx;
    logic [ByteW-1:0]     running_xor;
    logic [ByteW-1:0]     store [PayloadBytes];
    logic [CountOutW-1:0] good_frames;
    logic [CountOutW-1:0] bad_frames;

    function new();
      mismatches     = 0;
      words_seen     = 0;
      frames_checked = 0;
      n_good         = 0;
      n_bad_check    = 0;
      n_bad_length   = 0;
      start_byte     = 8'd2;
      max_length     = 5'd15;
      parse_phase    = PH_HUNT;
      frame_len      = '0;
      frame_cmd      = '0;
      byte_idx       = '0;
      running_xor    = '0;
      good_frames    = '0;
      bad_frames     = '0;
      foreach (store[i]) store[i] = '0;
    endfunction

    function void note_config(cfg_reg_e idx, logic [ByteW-1:0] data);
      case (idx)
        CFG_START_BYTE: start_byte = data;
        CFG_MAX_LENGTH: max_length = data[LenW-1:0];
        default: ;
      endcase
    endfunction

    // Queue the result of a finished frame; counters already include it
    function void close_frame(status_e st);
      result_t r;
      r = '0;
      r.status = st;
      if (st != ST_BAD_LENGTH) begin
        r.command        = frame_cmd;
        r.payload_length = frame_len;
        for (int i = 0; i < frame_len; i++) begin
          if (i < 8) r.payload_low[8*i +: 8] = store[i];
          else       r.payload_high[8*(i-8) +: 8] = store[i];
        end
      end
      r.good_count = good_frames;
      r.bad_count  = bad_frames;
      case (st)
        ST_GOOD:      n_good++;
        ST_BAD_CHECK: n_bad_check++;
        default:      n_bad_length++;
      endcase
      pending_frames.push_back(r);
    endfunction

    // Advance the parser copy by one accepted word
    function void note_rx_byte(logic [ByteW-1:0] b);
      int lim;
      lim = (max_length > PayloadBytes) ? PayloadBytes : max_length;
      words_seen++;
      case (parse_phase)
        PH_HUNT: begin
          if (b == start_byte) begin
            parse_phase = PH_LEN;
            running_xor = '0;
          end
        end
        PH_LEN: begin
          if (b > lim) begin
            parse_phase = PH_HUNT;
            bad_frames++;
            close_frame(ST_BAD_LENGTH);
          end else begin
            frame_len   = b[LenW-1:0];
            running_xor = b;
            parse_phase = PH_CMD;
          end
        end
        PH_CMD: begin
          frame_cmd   = b;
          running_xor = running_xor ^ b;
          byte_idx    = '0;
          parse_phase = (frame_len == 0) ? PH_CHECK : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          store[byte_idx[IdxW-1:0]] = b;
          byte_idx    = byte_idx + 1'b1;
          running_xor = running_xor ^ b;
          if (byte_idx >= frame_len) parse_phase = PH_CHECK;
        end
        PH_CHECK: begin
          parse_phase = PH_HUNT;
          if (b == running_xor) begin
            good_frames++;
            close_frame(ST_GOOD);
          end else begin
            bad_frames++;
            close_frame(ST_BAD_CHECK);
          end
        end
        default: parse_phase = PH_HUNT;
      endcase
    endfunction

    function void compare_field(string name, logic [WordW-1:0] want, logic [WordW-1:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t: %s expected %h actual %h", $time, name, want, got);
      end
    endfunction

    // Compare one output word with the oldest predicted frame
    function void check_frame(result_t got);
      result_t want;
      if (pending_frames.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected frame, expected none, actual status %0d cmd %h len %0d",
                 $time, got.status, got.command, got.payload_length);
        return;
      end
      want = pending_frames.pop_front();
      frames_checked++;
      compare_field("status", want.status, got.status);
      compare_field("command", want.command, got.command);
      compare_field("payload_length", want.payload_length, got.payload_length);
      compare_field("payload_low", want.payload_low, got.payload_low);
      compare_field("payload_high", want.payload_high, got.payload_high);
      compare_field("good_count", want.good_count, got.good_count);
      compare_field("bad_count", want.bad_count, got.bad_count);
    endfunction
  endclass

endpackage

[tb/xor_checked_frame_parser_test.sv]
// Testbench top for the XOR-checked frame parser: drives frames, noise and register writes.
module xor_checked_frame_parser_test;
  import xcfp_pkg::*;
  import xcfp_tb_pkg::*;

  localparam int WatchdogLimit = 5000;
  localparam int DrainCycles   = 8;
  localparam int BlockWords    = 84;
  localparam int HoldCycles    = 300;

  typedef enum int {
    FR_GOOD,
    FR_BAD_CHECK,
    FR_BAD_LENGTH,
    FR_NOISE,
    FR_TRUNCATED
  } frame_kind_e;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [ByteW-1:0]     rx_byte_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [StatusW-1:0]   status_o;
  logic [ByteW-1:0]     command_o;
  logic [LenW-1:0]      payload_length_o;
  logic [WordW-1:0]     payload_low_o;
  logic [WordW-1:0]     payload_high_o;
  logic [CountOutW-1:0] good_count_o;
  logic [CountOutW-1:0] bad_count_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i;
  logic [ByteW-1:0]     cfg_data_i;

  frame_ledger ledger;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          recv_hold_cycles;
  int          cur_start;
  int          cur_limit;
  int          settings_done;

  xor_checked_frame_parser u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .command_o       (command_o),
    .payload_length_o(payload_length_o),
    .payload_low_o   (payload_low_o),
    .payload_high_o  (payload_high_o),
    .good_count_o    (good_count_o),
    .bad_count_o     (bad_count_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Offer one word, idling first at random; leave valid high after acceptance
  task automatic send_byte(input logic [ByteW-1:0] b);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    ledger.note_rx_byte(b);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [ByteW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    ledger.note_config(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Write both registers and track the effective limit for stimulus
  task automatic apply_setting(input logic [ByteW-1:0] start, input logic [ByteW-1:0] maxdata);
    write_reg(CFG_START_BYTE, start);
    write_reg(CFG_MAX_LENGTH, maxdata);
    cur_start = start;
    cur_limit = (maxdata[LenW-1:0] > PayloadBytes) ? PayloadBytes : maxdata[LenW-1:0];
    settings_done++;
  endtask

  // Hold the sender until every predicted frame has come out, then let the pipe settle
  task automatic drain();
    while (ledger.pending_frames.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic send_frame(input frame_kind_e kind);
    int               len;
    int               cut;
    logic [ByteW-1:0] xsum;
    logic [ByteW-1:0] b;
    case (kind)
      FR_NOISE: send_byte(8'($urandom_range(0, 255)));
      FR_BAD_LENGTH: begin
        send_byte(8'(cur_start));
        send_byte(8'($urandom_range(cur_limit + 1, 255)));
      end
      default: begin
        len = $urandom_range(0, cur_limit);
        if (kind == FR_TRUNCATED && len == 0) len = cur_limit;
        cut = (kind == FR_TRUNCATED) ? $urandom_range(0, (len > 0) ? len - 1 : 0) : len;
        send_byte(8'(cur_start));
        send_byte(8'(len));
        xsum = 8'(len);
        b = 8'($urandom);
        send_byte(b);
        xsum ^= b;
        for (int i = 0; i < cut; i++) begin
          b = 8'($urandom);
          send_byte(b);
          xsum ^= b;
        end
        if (kind == FR_GOOD) send_byte(xsum);
        else if (kind == FR_BAD_CHECK) send_byte(xsum ^ 8'($urandom_range(1, 255)));
      end
    endcase
  endtask

  // Receiver: check each accepted word, then choose ready for the next cycle
  initial begin
    result_t seen;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        seen.status         = status_e'(status_o);
        seen.command        = command_o;
        seen.payload_length = payload_length_o;
        seen.payload_low    = payload_low_o;
        seen.payload_high   = payload_high_o;
        seen.good_count     = good_count_o;
        seen.bad_count      = bad_count_o;
        ledger.check_frame(seen);
      end
      if (recv_hold_cycles > 0) begin
        recv_hold_cycles--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: end the run after too long without any handshake
  initial begin
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Main sequence
  initial begin
    int mark;
    int pick;
    ledger           = new();
    send_idle_pct    = 6;
    recv_idle_pct    = 55;
    recv_hold_cycles = 0;
    cur_start        = 2;
    cur_limit        = 15;
    settings_done    = 0;
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    rx_byte_i        = '0;
    cfg_valid_i      = 1'b0;
    cfg_index_i      = '0;
    cfg_data_i       = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset settings, dropped noise, zero length, length just over the
    // limit, bad check byte, and extreme payload values
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h02); send_byte(8'h00); send_byte(8'hFF); send_byte(8'hFF);
    send_byte(8'h02); send_byte(8'h10);
    send_byte(8'h02); send_byte(8'h01); send_byte(8'h00); send_byte(8'hAA);
    send_byte(8'h00);
    send_byte(8'h02); send_byte(8'h02); send_byte(8'h00); send_byte(8'hFF);
    send_byte(8'h00); send_byte(8'hFD);
    in_valid_i <= 1'b0;
    drain();

    // Random frames over three idling profiles and rotating register settings
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle_pct = 6;  recv_idle_pct = 55; end
        1: begin send_idle_pct = 55; recv_idle_pct = 6;  end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int blk = 0; blk < 4; blk++) begin
        case (blk)
          0: apply_setting(8'h00, 8'hE0);
          1: apply_setting(8'hFF, 8'h10);
          2: apply_setting(8'h02, 8'hFF);
          default: apply_setting(8'($urandom), 8'($urandom));
        endcase
        // Stall the receiver for a long stretch so the block backs up its input
        if (ph == 2 && blk == 1) recv_hold_cycles = HoldCycles;
        mark = ledger.words_seen;
        while (ledger.words_seen - mark < BlockWords) begin
          pick = $urandom_range(0, 99);
          if (pick < 70)      send_frame(FR_GOOD);
          else if (pick < 80) send_frame(FR_BAD_CHECK);
          else if (pick < 88) send_frame(FR_BAD_LENGTH);
          else if (pick < 94) send_frame(FR_NOISE);
          else                send_frame(FR_TRUNCATED);
        end
        in_valid_i <= 1'b0;
        drain();
      end
    end

    $display("Covered %0d input words and %0d frames under %0d register settings.",
             ledger.words_seen, ledger.frames_checked, settings_done + 1);
    $display("Frames: %0d good, %0d bad check, %0d bad length; %0d mismatches.",
             ledger.n_good, ledger.n_bad_check, ledger.n_bad_length, ledger.mismatches);
    if (ledger.mismatches == 0 && ledger.pending_frames.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[xor_checked_frame_parser.f]
src/xcfp_pkg.sv
src/xcfp_in_reg.sv
src/xcfp_deframer.sv
src/xcfp_out_reg.sv
src/xor_checked_frame_parser.sv
src/xcfp_checker.sv
tb/xcfp_tb_pkg.sv
tb/xor_checked_frame_parser_test.sv
